FILE: design/btbb_pkg.sv
// Shared types, constants and helpers for the bloom threshold box blur block.
// No dependencies; btbb_thresh and the top module import it, btbb_cfg_if uses its widths.
package btbb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int BLUR_RADIUS = 4;
  localparam int TAPS        = 2 * BLUR_RADIUS + 1;
  localparam int WIN         = 2 * BLUR_RADIUS;

  localparam int DIM_CFG_W = 11;
  localparam int GAIN_W    = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = DIM_CFG_W'(640);
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = DIM_CFG_W'(480);
  localparam logic [GAIN_W-1:0]    GAIN_RST   = GAIN_W'(256);

  // luma weights, 16-bit fixed point
  localparam logic [23:0] LUMA_R      = 24'd19595;
  localparam logic [23:0] LUMA_G      = 24'd38470;
  localparam logic [23:0] LUMA_B      = 24'd7471;
  localparam logic [24:0] LUMA_THRESH = 25'd13369344;
  // span = 51 << 16; divide by 51 as multiply by ceil(2^20 / 51)
  localparam logic [28:0] RECIP_51    = 29'd20561;

  // divide by TAPS: multiply by ceil(2^DIV_SH / TAPS)
  localparam int DIV_SH = 20;
  localparam int RECIP  = ((1 << DIV_SH) + TAPS - 1) / TAPS;
  localparam int RECW   = $clog2(RECIP + 1);
  localparam int HSW    = $clog2(TAPS * 255 + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BLOOM_GAIN   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THRESH,
    ST_HSUM,
    ST_HDIV,
    ST_VSUM,
    ST_VDIV,
    ST_BLEND
  } state_t;

  function automatic logic [7:0] div_taps(input logic [HSW-1:0] s);
    logic [HSW+RECW-1:0] p;
    p = (HSW+RECW)'(s) * (HSW+RECW)'(RECIP);
    return p[DIV_SH+7:DIV_SH];
  endfunction

endpackage

FILE: design/btbb_in_if.sv
// Input pixel channel: valid/ready handshake with operation and RGB payload.
// Depends on nothing.
interface btbb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, operation, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, operation, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

FILE: design/btbb_out_if.sv
// Result channel: valid/ready handshake with blended RGB and frame_last.
// Depends on nothing.
interface btbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

FILE: design/btbb_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on btbb_pkg for field widths.
interface btbb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [btbb_pkg::CFG_IDX_W-1:0]  index;
  logic [btbb_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/btbb_thresh.sv
// Four-stage free-running bright-pass pipeline: luma, excess over threshold,
// per-channel scale and divide by the span. Depends on btbb_pkg.
module btbb_thresh (
  input  logic            clk,
  input  btbb_pkg::rgb_t  pix_i,
  output btbb_pkg::rgb_t  bright_o
);
  import btbb_pkg::*;

  logic [23:0] pr_r, pg_r, pb_r;
  rgb_t        p1_r, p2_r;
  logic [21:0] e_r;
  logic [13:0] cr_r, cg_r, cb_r;
  logic [24:0] luma;
  logic [29:0] mr, mg, mb;
  logic [28:0] dr, dg, db;

  always_comb begin
    luma = 25'(pr_r) + 25'(pg_r) + 25'(pb_r);
    mr = 30'(p2_r.r) * 30'(e_r);
    mg = 30'(p2_r.g) * 30'(e_r);
    mb = 30'(p2_r.b) * 30'(e_r);
    dr = 29'(cr_r) * RECIP_51;
    dg = 29'(cg_r) * RECIP_51;
    db = 29'(cb_r) * RECIP_51;
  end

  always_ff @(posedge clk) begin
    pr_r <= LUMA_R * 24'(pix_i.r);
    pg_r <= LUMA_G * 24'(pix_i.g);
    pb_r <= LUMA_B * 24'(pix_i.b);
    p1_r <= pix_i;
    // at or below threshold the excess is zero, so the scale gives zero
    e_r  <= (luma > LUMA_THRESH) ? 22'(luma - LUMA_THRESH) : '0;
    p2_r <= p1_r;
    cr_r <= mr[29:16];
    cg_r <= mg[29:16];
    cb_r <= mb[29:16];
    bright_o.r <= dr[27:20];
    bright_o.g <= dg[27:20];
    bright_o.b <= db[27:20];
  end

endmodule

FILE: design/bloom_threshold_box_blur.sv
// Bloom: bright-pass, separable box blur over line buffers, gain blend.
// Pixel beat: a new beat is taken only once the last one has left the blend state;
// the eight reads of the single line-buffer port set the run, the threshold pipeline
// overlaps them. An emitting drain beat goes from idle to the blend state and on to the
// result register; an ignored drain leaves the block idle. A held result stalls input.
// Sync active-low reset clears control only; memories hold no reset.
module bloom_threshold_box_blur #(
  parameter int MAX_WIDTH  = btbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = btbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  btbb_in_if.sink     in_chan,
  btbb_out_if.source  out_chan,
  btbb_cfg_if.sink    cfg_chan
);
  import btbb_pkg::*;

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT);
  localparam int DIMW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW   = $clog2(MAX_HEIGHT + 1);
  localparam int EXW0  = (DIMW > DIM_CFG_W) ? DIMW : DIM_CFG_W;
  localparam int EXW   = (HDW > EXW0) ? HDW : EXW0;
  localparam int DEPTH = BLUR_RADIUS * MAX_WIDTH + BLUR_RADIUS;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int PENDW = $clog2(DEPTH + 1);
  localparam int SLW   = $clog2(WIN);
  localparam int HLW   = SLW + COLW;

  state_t state_r, state_nxt;

  logic [DIM_CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [GAIN_W-1:0]    gain_r;

  logic [COLW-1:0]  x_r, ox_r;
  logic [ROWW-1:0]  y_r, oy_r;
  logic [SLW-1:0]   yslot_r;
  logic [PENDW-1:0] pend_r;
  logic [PTRW-1:0]  rp_r, wp_r;
  logic [1:0]       thr_cnt_r;

  logic is_emit_r, is_pix_r, interior_r, xwin_r;
  rgb_t px_r, br, hv_r, bloom_r, odata_r, hrd_r;
  rgb_t win_r [WIN];
  logic [HSW-1:0] hs_red, hs_green, hs_blue;
  logic [HSW-1:0] hsum_r [3];
  logic [HSW-1:0] vacc_r [3];
  logic [HSW-1:0] vsum_r [3];

  logic [SLW-1:0] vcnt_r;
  logic           vact_r, vdv_r;

  logic       out_valid_r, out_last_r;
  rgb_t       out_pix_r;

  rgb_t hline_mem [WIN * (2**COLW)];
  rgb_t orig_mem  [DEPTH];

  // effective frame size
  logic [EXW-1:0]   wx, hx;
  logic [DIMW-1:0]  w_eff;
  logic [HDW-1:0]   h_eff;
  logic [PENDW-1:0] lag;

  always_comb begin
    wx = EXW'(cfg_w_r);
    if (wx < EXW'(TAPS)) wx = EXW'(TAPS);
    else if (wx > EXW'(MAX_WIDTH)) wx = EXW'(MAX_WIDTH);
    hx = EXW'(cfg_h_r);
    if (hx < EXW'(TAPS)) hx = EXW'(TAPS);
    else if (hx > EXW'(MAX_HEIGHT)) hx = EXW'(MAX_HEIGHT);
    w_eff = DIMW'(wx);
    h_eff = HDW'(hx);
    lag = PENDW'(BLUR_RADIUS) * PENDW'(w_eff) + PENDW'(BLUR_RADIUS);
  end

  logic in_acc, cfg_acc, is_drain, drain_ok, out_free, blend_go, vbusy;
  logic emit_now, interior_now, xwin_now, size_write;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc   = in_chan.valid & in_chan.ready;
  assign cfg_acc  = cfg_chan.valid & cfg_chan.ready;
  assign is_drain = (op_t'(in_chan.operation) == OP_DRAIN);
  assign drain_ok = (pend_r != '0) && (x_r == '0) && (y_r == '0);
  assign out_free = !out_valid_r || out_chan.ready;
  assign blend_go = (state_r == ST_BLEND) && (out_free || !is_emit_r);
  assign vbusy    = vact_r | vdv_r;
  assign size_write = cfg_acc &&
                      ((reg_idx_t'(cfg_chan.index) == REG_FRAME_WIDTH) ||
                       (reg_idx_t'(cfg_chan.index) == REG_FRAME_HEIGHT));

  assign emit_now     = (pend_r >= lag);
  assign xwin_now     = (DIMW'(x_r) >= DIMW'(WIN));
  assign interior_now = (DIMW'(ox_r) >= DIMW'(BLUR_RADIUS)) &&
                        (DIMW'(ox_r) < w_eff - DIMW'(BLUR_RADIUS)) &&
                        (HDW'(oy_r) >= HDW'(BLUR_RADIUS)) &&
                        (HDW'(oy_r) < h_eff - HDW'(BLUR_RADIUS)) && xwin_now;

  btbb_thresh u_thresh (
    .clk      (clk),
    .pix_i    (px_r),
    .bright_o (br)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_drain) state_nxt = ST_THRESH;
          else if (drain_ok) state_nxt = ST_BLEND;
        end
      end
      ST_THRESH: if (thr_cnt_r == 2'd3) state_nxt = ST_HSUM;
      ST_HSUM:   state_nxt = ST_HDIV;
      ST_HDIV:   state_nxt = ST_VSUM;
      ST_VSUM:   if (!vbusy) state_nxt = ST_VDIV;
      ST_VDIV:   state_nxt = ST_BLEND;
      ST_BLEND:  if (blend_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // horizontal window sum
  always_comb begin
    hs_red   = HSW'(br.r);
    hs_green = HSW'(br.g);
    hs_blue  = HSW'(br.b);
    for (int k = 0; k < WIN; k++) begin
      hs_red   = hs_red + HSW'(win_r[k].r);
      hs_green = hs_green + HSW'(win_r[k].g);
      hs_blue  = hs_blue + HSW'(win_r[k].b);
    end
  end

  // blend
  logic [19:0] gr, gg, gb;
  logic [12:0] sr, sg, sb;
  rgb_t        blend;
  logic        last_now;

  always_comb begin
    gr = 20'(bloom_r.r) * 20'(gain_r);
    gg = 20'(bloom_r.g) * 20'(gain_r);
    gb = 20'(bloom_r.b) * 20'(gain_r);
    sr = 13'(odata_r.r) + 13'(gr[19:8]);
    sg = 13'(odata_r.g) + 13'(gg[19:8]);
    sb = 13'(odata_r.b) + 13'(gb[19:8]);
    blend.r = (sr > 13'd255) ? 8'hFF : sr[7:0];
    blend.g = (sg > 13'd255) ? 8'hFF : sg[7:0];
    blend.b = (sb > 13'd255) ? 8'hFF : sb[7:0];
    last_now = (DIMW'(ox_r) == w_eff - DIMW'(1)) && (HDW'(oy_r) == h_eff - HDW'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= WIDTH_RST;
      cfg_h_r     <= HEIGHT_RST;
      gain_r      <= GAIN_RST;
      x_r         <= '0;
      y_r         <= '0;
      yslot_r     <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      pend_r      <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      thr_cnt_r   <= '0;
      vact_r      <= 1'b0;
      vdv_r       <= 1'b0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      is_emit_r   <= 1'b0;
      is_pix_r    <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (reg_idx_t'(cfg_chan.index))
          REG_FRAME_WIDTH:  cfg_w_r <= cfg_chan.data[DIM_CFG_W-1:0];
          REG_FRAME_HEIGHT: cfg_h_r <= cfg_chan.data[DIM_CFG_W-1:0];
          REG_BLOOM_GAIN:   gain_r <= cfg_chan.data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;

      thr_cnt_r <= (state_r == ST_THRESH) ? thr_cnt_r + 2'd1 : 2'd0;

      if (in_acc) begin
        is_pix_r  <= !is_drain;
        is_emit_r <= is_drain ? 1'b1 : emit_now;
      end

      // line-buffer column reads
      vdv_r <= vact_r;
      if (in_acc && !is_drain) begin
        vact_r <= 1'b1;
        vcnt_r <= '0;
      end else if (vact_r) begin
        vcnt_r <= vcnt_r + SLW'(1);
        if (vcnt_r == SLW'(WIN - 1)) vact_r <= 1'b0;
      end

      if (blend_go) begin
        if (is_emit_r) begin
          out_valid_r <= 1'b1;
          rp_r <= (rp_r == PTRW'(DEPTH - 1)) ? '0 : rp_r + PTRW'(1);
          if (DIMW'(ox_r) + DIMW'(1) >= w_eff) begin
            ox_r <= '0;
            oy_r <= (HDW'(oy_r) + HDW'(1) >= h_eff) ? '0 : oy_r + ROWW'(1);
          end else begin
            ox_r <= ox_r + COLW'(1);
          end
        end
        if (is_pix_r) begin
          wp_r <= (wp_r == PTRW'(DEPTH - 1)) ? '0 : wp_r + PTRW'(1);
          if (DIMW'(x_r) + DIMW'(1) >= w_eff) begin
            x_r <= '0;
            if (HDW'(y_r) + HDW'(1) >= h_eff) begin
              y_r     <= '0;
              yslot_r <= '0;
            end else begin
              y_r     <= y_r + ROWW'(1);
              yslot_r <= (yslot_r == SLW'(WIN - 1)) ? '0 : yslot_r + SLW'(1);
            end
          end else begin
            x_r <= x_r + COLW'(1);
          end
        end
        pend_r <= pend_r + PENDW'(is_pix_r) - PENDW'(is_emit_r);
      end

      // a size write restarts the stream
      if (size_write) begin
        x_r     <= '0;
        y_r     <= '0;
        yslot_r <= '0;
        ox_r    <= '0;
        oy_r    <= '0;
        pend_r  <= '0;
        rp_r    <= '0;
        wp_r    <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r.r     <= in_chan.pixel_red;
      px_r.g     <= in_chan.pixel_green;
      px_r.b     <= in_chan.pixel_blue;
      interior_r <= interior_now;
      xwin_r     <= xwin_now;
      bloom_r    <= '0;
      for (int c = 0; c < 3; c++) vacc_r[c] <= '0;
    end else if (vdv_r) begin
      vacc_r[0] <= vacc_r[0] + HSW'(hrd_r.r);
      vacc_r[1] <= vacc_r[1] + HSW'(hrd_r.g);
      vacc_r[2] <= vacc_r[2] + HSW'(hrd_r.b);
    end

    if (state_r == ST_HSUM) begin
      hsum_r[0] <= hs_red;
      hsum_r[1] <= hs_green;
      hsum_r[2] <= hs_blue;
    end
    if (state_r == ST_HDIV) begin
      hv_r.r <= xwin_r ? div_taps(hsum_r[0]) : 8'd0;
      hv_r.g <= xwin_r ? div_taps(hsum_r[1]) : 8'd0;
      hv_r.b <= xwin_r ? div_taps(hsum_r[2]) : 8'd0;
    end
    if (state_r == ST_VSUM) begin
      vsum_r[0] <= vacc_r[0] + HSW'(hv_r.r);
      vsum_r[1] <= vacc_r[1] + HSW'(hv_r.g);
      vsum_r[2] <= vacc_r[2] + HSW'(hv_r.b);
    end
    if (state_r == ST_VDIV) begin
      bloom_r.r <= interior_r ? div_taps(vsum_r[0]) : 8'd0;
      bloom_r.g <= interior_r ? div_taps(vsum_r[1]) : 8'd0;
      bloom_r.b <= interior_r ? div_taps(vsum_r[2]) : 8'd0;
    end

    if (blend_go && is_emit_r) begin
      out_pix_r  <= blend;
      out_last_r <= last_now;
    end

    if (blend_go && is_pix_r) begin
      for (int k = 0; k < WIN - 1; k++) win_r[k] <= win_r[k + 1];
      win_r[WIN - 1] <= br;
    end
  end

  // original-pixel delay line
  always_ff @(posedge clk) begin
    if (in_acc) odata_r <= orig_mem[rp_r];
    if (blend_go && is_pix_r) orig_mem[wp_r] <= px_r;
  end

  // horizontal-average line buffer; all WIN row slots of one column are read
  always_ff @(posedge clk) begin
    if (vact_r) hrd_r <= hline_mem[HLW'({vcnt_r, ox_r})];
    if (blend_go && is_pix_r && xwin_r)
      hline_mem[HLW'({yslot_r, COLW'(x_r - COLW'(BLUR_RADIUS))})] <= hv_r;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_red    = out_pix_r.r;
  assign out_chan.out_green  = out_pix_r.g;
  assign out_chan.out_blue   = out_pix_r.b;
  assign out_chan.frame_last = out_last_r;

endmodule
